>>> sv/jacobi_linear_system_solver_assert.svh
`ifndef JACOBI_LINEAR_SYSTEM_SOLVER_ASSERT_SVH
`define JACOBI_LINEAR_SYSTEM_SOLVER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define JLS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define JLS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/jls_pkg.sv
package jls_pkg;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int QUO_W       = 48;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAP  = 2'd2;

    localparam logic [4:0]  SIZE_RST = 5'd16;
    localparam logic [16:0] TOL_RST  = 17'd66;
    localparam logic [15:0] CAP_RST  = 16'd1000;

    localparam logic [1:0] OUT_CONVERGED    = 2'd0;
    localparam logic [1:0] OUT_NOT_DOMINANT = 2'd1;
    localparam logic [1:0] OUT_CAP_REACHED  = 2'd2;

    typedef struct packed {
        logic             start;
        logic             num_neg;
        logic [QUO_W-1:0] num_mag;
        logic             den_neg;
        logic [31:0]      den_mag;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [31:0] quot;
    } div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        logic [31:0] r;
        r = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

endpackage

>>> sv/jacobi_linear_system_solver.sv
// Jacobi solver for a dense n-by-n system in signed Q16.16.
// Input stream: one word per matrix element (row, column, value); column n
// carries the right-hand side. tlast on a word stores it if in range and starts the solve.
// Words are taken one per cycle while loading; tready stays low during a solve.
// The solve checks row diagonal dominance, rewrites the coefficient memory
// into iteration form (one quotient per off-diagonal element and per
// right-hand side from the bit-serial 48-step divider), then runs sweeps
// that read one coefficient per cycle through the single read port of the
// coefficient memory.
// Output stream: n words (index, value, outcome), tlast on the last one, or a
// single status word when the system is not dominant.
// The result sits in an output register: a stalled receiver holds the solver
// before each word, and the next load may start while the last word waits.
// Reset sets size 16, tolerance 66, cap 1000 and empties the output register;
// the coefficient memory is not cleared and must be loaded before a solve.
// The user must write configuration via cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
`include "jacobi_linear_system_solver_assert.svh"

module jacobi_linear_system_solver #(
    parameter int MAX_UNKNOWNS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // row_index[3:0], column_index[8:4], element_value[40:9]
    input  logic [jls_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // unknown_index[3:0], solution_value[35:4], outcome[37:36]
    output logic [jls_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast,
    input  logic                              cfg_we,
    input  logic [jls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jls_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import jls_pkg::*;

    localparam int COLS   = MAX_UNKNOWNS + 1;
    localparam int IW     = $clog2(MAX_UNKNOWNS);
    localparam int NW     = $clog2(MAX_UNKNOWNS + 1);
    localparam int CDEPTH = MAX_UNKNOWNS * COLS;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int EDEPTH = 2 ** (IW + 1);
    localparam int ACC_W  = 32 + NW;
    localparam int SUM_W  = 32 + IW;

    typedef enum logic [10:0] {
        S_LOAD  = 11'b00000000001,
        S_DOM   = 11'b00000000010,
        S_FDRD  = 11'b00000000100,
        S_FDCAP = 11'b00000001000,
        S_FRD   = 11'b00000010000,
        S_FCAP  = 11'b00000100000,
        S_FDIV  = 11'b00001000000,
        S_SWEEP = 11'b00010000000,
        S_ORD   = 11'b00100000000,
        S_OPUT  = 11'b01000000000,
        S_ND    = 11'b10000000000
    } state_t;

    function automatic logic [CAW-1:0] caddr(input logic [IW-1:0] r, input logic [NW-1:0] c);
        return CAW'(r) * CAW'(COLS) + CAW'(c);
    endfunction

    // control
    state_t              state_reg, state_next;
    logic                iss_reg, iss_next;
    logic                a_v_reg, a_v_next;
    logic                b_v_reg, b_v_next;
    logic                c_v_reg, c_v_next;
    logic                first_reg, first_next;
    logic                rbank_reg, rbank_next;
    logic                out_valid_reg, out_valid_next;
    logic [4:0]          size_reg, size_next;
    logic [16:0]         tol_reg, tol_next;
    logic [15:0]         cap_reg, cap_next;
    logic [15:0]         sweep_count_reg, sweep_count_next;

    // datapath
    logic [IW-1:0]       si_reg, si_next;
    logic [NW-1:0]       sj_reg, sj_next;
    logic [NW-1:0]       n_reg, n_next;
    logic                a_diag_reg, a_diag_next;
    logic                a_isc_reg, a_isc_next;
    logic                a_lastcol_reg, a_lastcol_next;
    logic                a_lastrow_reg, a_lastrow_next;
    logic [IW-1:0]       a_row_reg, a_row_next;
    logic                b_isc_reg, b_isc_next;
    logic signed [63:0]  b_val_reg, b_val_next;
    logic [IW-1:0]       b_row_reg, b_row_next;
    logic                b_lastrow_reg, b_lastrow_next;
    logic signed [31:0]  c_xnew_reg, c_xnew_next;
    logic signed [31:0]  c_xold_reg, c_xold_next;
    logic [IW-1:0]       c_row_reg, c_row_next;
    logic                c_lastrow_reg, c_lastrow_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [31:0]         diag_reg, diag_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [31:0]         d_reg, d_next;
    logic signed [31:0]  xold_reg, xold_next;
    logic [31:0]         largest_reg, largest_next;
    logic [1:0]          outcome_reg, outcome_next;
    logic [3:0]          o_idx_reg, o_idx_next;
    logic [31:0]         o_val_reg, o_val_next;
    logic [1:0]          o_out_reg, o_out_next;
    logic                o_last_reg, o_last_next;

    // memories
    logic                c_we;
    logic [CAW-1:0]      c_waddr, c_raddr;
    logic [31:0]         c_wdata, c_rdata;
    logic                e_we;
    logic [IW:0]         e_waddr, e_raddr;
    logic [31:0]         e_wdata, e_rdata;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    // combinational helpers
    logic [3:0]          in_row;
    logic [4:0]          in_col;
    logic [31:0]         in_val;
    logic                in_acc;
    logic                in_ok;
    logic [NW-1:0]       n_new;
    logic [15:0]         cap_eff;
    logic [NW-1:0]       colmax;
    logic [31:0]         abs_a;
    logic [31:0]         diag_eff;
    logic [SUM_W-1:0]    sum_eff;
    logic signed [31:0]  ma;
    logic signed [31:0]  xa;
    logic signed [63:0]  prod;
    logic signed [63:0]  term;
    logic signed [ACC_W-1:0] acc_sum;
    logic [32:0]         d33;
    logic [32:0]         dabs;
    logic [31:0]         cand;
    logic                out_load;
    logic                out_free;
    logic                f_adv;

    jls_ram #(.WIDTH(32), .DEPTH(CDEPTH)) u_coef (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    jls_ram #(.WIDTH(32), .DEPTH(EDEPTH)) u_est (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    jls_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_row        = s_axis_tdata[3:0];
    assign in_col        = s_axis_tdata[8:4];
    assign in_val        = s_axis_tdata[40:9];
    assign s_axis_tready = state_reg == S_LOAD;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_ok         = (32'(in_row) < MAX_UNKNOWNS) && (32'(in_col) <= MAX_UNKNOWNS);
    assign cap_eff       = (cap_reg == 16'd0) ? 16'd1 : cap_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, o_out_reg, o_val_reg, o_idx_reg};
    assign m_axis_tlast  = o_last_reg;

    always_comb
    begin
        if (size_reg == 5'd0)
            n_new = NW'(1);
        else if (32'(size_reg) > MAX_UNKNOWNS)
            n_new = NW'(MAX_UNKNOWNS);
        else
            n_new = NW'(size_reg);
    end

    always_comb
    begin
        state_next       = state_reg;
        iss_next         = iss_reg;
        a_v_next         = 1'b0;
        b_v_next         = 1'b0;
        c_v_next         = 1'b0;
        first_next       = first_reg;
        rbank_next       = rbank_reg;
        out_valid_next   = out_valid_reg;
        size_next        = size_reg;
        tol_next         = tol_reg;
        cap_next         = cap_reg;
        sweep_count_next = sweep_count_reg;
        si_next          = si_reg;
        sj_next          = sj_reg;
        n_next           = n_reg;
        a_diag_next      = a_diag_reg;
        a_isc_next       = a_isc_reg;
        a_lastcol_next   = a_lastcol_reg;
        a_lastrow_next   = a_lastrow_reg;
        a_row_next       = a_row_reg;
        b_isc_next       = b_isc_reg;
        b_val_next       = b_val_reg;
        b_row_next       = b_row_reg;
        b_lastrow_next   = b_lastrow_reg;
        c_xnew_next      = c_xnew_reg;
        c_xold_next      = c_xold_reg;
        c_row_next       = c_row_reg;
        c_lastrow_next   = c_lastrow_reg;
        acc_next         = acc_reg;
        diag_next        = diag_reg;
        sum_next         = sum_reg;
        d_next           = d_reg;
        xold_next        = xold_reg;
        largest_next     = largest_reg;
        outcome_next     = outcome_reg;
        o_idx_next       = o_idx_reg;
        o_val_next       = o_val_reg;
        o_out_next       = o_out_reg;
        o_last_next      = o_last_reg;

        c_we    = 1'b0;
        c_waddr = caddr(si_reg, sj_reg);
        c_wdata = '0;
        c_raddr = caddr(si_reg, sj_reg);
        e_we    = 1'b0;
        e_waddr = {~rbank_reg, c_row_reg};
        e_wdata = c_xnew_reg;
        e_raddr = {rbank_reg, IW'(sj_reg)};
        out_load = 1'b0;
        f_adv    = 1'b0;

        div_req.start   = 1'b0;
        div_req.den_neg = d_reg[31];
        div_req.den_mag = abs32(d_reg);
        div_req.num_neg = (sj_reg == n_reg) ? c_rdata[31] : ~c_rdata[31];
        div_req.num_mag = {abs32(c_rdata), 16'd0};

        colmax   = (state_reg == S_DOM) ? (n_reg - 1'b1) : n_reg;
        abs_a    = abs32(c_rdata);
        diag_eff = a_diag_reg ? abs_a : diag_reg;
        sum_eff  = a_diag_reg ? sum_reg : (sum_reg + SUM_W'(abs_a));
        ma       = $signed(c_rdata);
        xa       = first_reg ? 32'sd0 : $signed(e_rdata);
        prod     = ma * xa;
        term     = b_isc_reg ? b_val_reg : 64'(sat32(b_val_reg >>> 16));
        acc_sum  = acc_reg + ACC_W'(term);
        d33      = {c_xnew_reg[31], c_xnew_reg} - {c_xold_reg[31], c_xold_reg};
        dabs     = d33[32] ? (~d33 + 33'd1) : d33;
        cand     = (dabs[31:0] > largest_reg) ? dabs[31:0] : largest_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SIZE: size_next = cfg_data[4:0];
                REG_TOL:  tol_next  = cfg_data;
                REG_CAP:  cap_next  = cfg_data[15:0];
                default:  ;
            endcase
        end

        // issue one memory read per cycle during the check and the sweeps
        if (iss_reg && (state_reg == S_DOM || state_reg == S_SWEEP))
        begin
            a_v_next       = 1'b1;
            a_diag_next    = sj_reg == NW'(si_reg);
            a_isc_next     = sj_reg == n_reg;
            a_lastcol_next = sj_reg == colmax;
            a_lastrow_next = NW'(si_reg) == (n_reg - 1'b1);
            a_row_next     = si_reg;
            if (sj_reg == colmax)
            begin
                sj_next = '0;
                if (NW'(si_reg) == (n_reg - 1'b1))
                    iss_next = 1'b0;
                else
                    si_next = si_reg + 1'b1;
            end
            else
            begin
                sj_next = sj_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_LOAD:
            begin
                c_waddr = caddr(IW'(in_row), NW'(in_col));
                c_wdata = in_val;
                c_we    = in_acc && in_ok;
                if (in_acc && s_axis_tlast)
                begin
                    state_next = S_DOM;
                    n_next     = n_new;
                    si_next    = '0;
                    sj_next    = '0;
                    iss_next   = 1'b1;
                    diag_next  = '0;
                    sum_next   = '0;
                end
            end
            S_DOM:
            begin
                if (a_v_reg)
                begin
                    if (a_diag_reg)
                        diag_next = abs_a;
                    else
                        sum_next = sum_eff;
                    if (a_lastcol_reg)
                    begin
                        sum_next = '0;
                        if (SUM_W'(diag_eff) <= sum_eff)
                        begin
                            state_next = S_ND;
                            iss_next   = 1'b0;
                        end
                        else if (a_lastrow_reg)
                        begin
                            state_next = S_FDRD;
                            si_next    = '0;
                            sj_next    = '0;
                        end
                    end
                end
            end
            S_FDRD:
            begin
                c_raddr    = caddr(si_reg, NW'(si_reg));
                state_next = S_FDCAP;
            end
            S_FDCAP:
            begin
                c_raddr    = caddr(si_reg, NW'(si_reg));
                d_next     = c_rdata;
                state_next = S_FRD;
            end
            S_FRD:
            begin
                state_next = S_FCAP;
            end
            S_FCAP:
            begin
                if (sj_reg == NW'(si_reg))
                begin
                    c_we  = 1'b1;
                    f_adv = 1'b1;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_FDIV;
                end
            end
            S_FDIV:
            begin
                if (div_rsp.done)
                begin
                    c_we    = 1'b1;
                    c_wdata = div_rsp.quot;
                    f_adv   = 1'b1;
                end
            end
            S_SWEEP:
            begin
                // stage A: memory data; stage B: product; stage C: row result
                if (a_v_reg)
                begin
                    if (a_diag_reg)
                        xold_next = xa;
                    b_v_next       = 1'b1;
                    b_isc_next     = a_isc_reg;
                    b_val_next     = a_isc_reg ? 64'(ma) : prod;
                    b_row_next     = a_row_reg;
                    b_lastrow_next = a_lastrow_reg;
                end
                if (b_v_reg)
                begin
                    if (b_isc_reg)
                    begin
                        c_v_next       = 1'b1;
                        c_xnew_next    = sat32(64'(acc_sum));
                        c_xold_next    = xold_reg;
                        c_row_next     = b_row_reg;
                        c_lastrow_next = b_lastrow_reg;
                        acc_next       = '0;
                    end
                    else
                    begin
                        acc_next = acc_sum;
                    end
                end
                if (c_v_reg)
                begin
                    e_we         = 1'b1;
                    largest_next = cand;
                    if (c_lastrow_reg)
                    begin
                        sweep_count_next = sweep_count_reg + 16'd1;
                        rbank_next       = ~rbank_reg;
                        first_next       = 1'b0;
                        if (cand <= 32'(tol_reg))
                        begin
                            outcome_next = OUT_CONVERGED;
                            state_next   = S_ORD;
                            si_next      = '0;
                        end
                        else if ((sweep_count_reg + 16'd1) >= cap_eff)
                        begin
                            outcome_next = OUT_CAP_REACHED;
                            state_next   = S_ORD;
                            si_next      = '0;
                        end
                        else
                        begin
                            largest_next = '0;
                            iss_next     = 1'b1;
                            si_next      = '0;
                            sj_next      = '0;
                        end
                    end
                end
            end
            S_ORD:
            begin
                e_raddr    = {rbank_reg, si_reg};
                state_next = S_OPUT;
            end
            S_OPUT:
            begin
                e_raddr = {rbank_reg, si_reg};
                if (out_free)
                begin
                    out_load    = 1'b1;
                    o_idx_next  = 4'(si_reg);
                    o_val_next  = e_rdata;
                    o_out_next  = outcome_reg;
                    o_last_next = NW'(si_reg) == (n_reg - 1'b1);
                    if (NW'(si_reg) == (n_reg - 1'b1))
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        si_next    = si_reg + 1'b1;
                        state_next = S_ORD;
                    end
                end
            end
            S_ND:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    o_idx_next  = '0;
                    o_val_next  = '0;
                    o_out_next  = OUT_NOT_DOMINANT;
                    o_last_next = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // advance through the row while rewriting to iteration form
        if (f_adv)
        begin
            if (sj_reg == n_reg)
            begin
                sj_next = '0;
                if (NW'(si_reg) == (n_reg - 1'b1))
                begin
                    state_next       = S_SWEEP;
                    si_next          = '0;
                    iss_next         = 1'b1;
                    acc_next         = '0;
                    largest_next     = '0;
                    sweep_count_next = '0;
                    first_next       = 1'b1;
                    rbank_next       = 1'b0;
                end
                else
                begin
                    si_next    = si_reg + 1'b1;
                    state_next = S_FDRD;
                end
            end
            else
            begin
                sj_next    = sj_reg + 1'b1;
                state_next = S_FRD;
            end
        end

        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            iss_reg         <= 1'b0;
            a_v_reg         <= 1'b0;
            b_v_reg         <= 1'b0;
            c_v_reg         <= 1'b0;
            first_reg       <= 1'b1;
            rbank_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            size_reg        <= SIZE_RST;
            tol_reg         <= TOL_RST;
            cap_reg         <= CAP_RST;
            sweep_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            iss_reg         <= iss_next;
            a_v_reg         <= a_v_next;
            b_v_reg         <= b_v_next;
            c_v_reg         <= c_v_next;
            first_reg       <= first_next;
            rbank_reg       <= rbank_next;
            out_valid_reg   <= out_valid_next;
            size_reg        <= size_next;
            tol_reg         <= tol_next;
            cap_reg         <= cap_next;
            sweep_count_reg <= sweep_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg        <= si_next;
        sj_reg        <= sj_next;
        n_reg         <= n_next;
        a_diag_reg    <= a_diag_next;
        a_isc_reg     <= a_isc_next;
        a_lastcol_reg <= a_lastcol_next;
        a_lastrow_reg <= a_lastrow_next;
        a_row_reg     <= a_row_next;
        b_isc_reg     <= b_isc_next;
        b_val_reg     <= b_val_next;
        b_row_reg     <= b_row_next;
        b_lastrow_reg <= b_lastrow_next;
        c_xnew_reg    <= c_xnew_next;
        c_xold_reg    <= c_xold_next;
        c_row_reg     <= c_row_next;
        c_lastrow_reg <= c_lastrow_next;
        acc_reg       <= acc_next;
        diag_reg      <= diag_next;
        sum_reg       <= sum_next;
        d_reg         <= d_next;
        xold_reg      <= xold_next;
        largest_reg   <= largest_next;
        outcome_reg   <= outcome_next;
        o_idx_reg     <= o_idx_next;
        o_val_reg     <= o_val_next;
        o_out_reg     <= o_out_next;
        o_last_reg    <= o_last_next;
    end

    `JLS_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
    `JLS_ASSERT_IMP(a_div_done_wait, div_rsp.done, state_reg == S_FDIV, "quotient with no consumer")
    `JLS_ASSERT_IMP(a_out_load_free, out_load, !out_valid_reg || m_axis_tready, "output word overwritten")
    `JLS_ASSERT_IMP(a_sweep_below_cap, state_reg == S_SWEEP, sweep_count_reg < cap_eff, "sweep past cap")
    `JLS_ASSERT_NXT(a_load_after_last, out_load && o_last_next, state_reg == S_LOAD, "no return to load")

endmodule

>>> sv/jls_ram.sv
module jls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/jls_div.sv
module jls_div (
    input  logic               clk,
    input  logic               rst_n,
    input  jls_pkg::div_req_t  req,
    output jls_pkg::div_rsp_t  rsp
);
    import jls_pkg::*;

    localparam int CW = $clog2(QUO_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [31:0]      rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [31:0]      den_reg;
    logic             neg_reg;

    logic [32:0]      trial;
    logic             fits;
    logic [32:0]      rem_next;
    logic             big;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[QUO_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? (trial - {1'b0, den_reg}) : trial;
        big      = quo_reg[QUO_W-1:31] != '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.num_mag;
            den_reg <= req.den_mag;
            neg_reg <= req.num_neg ^ req.den_neg;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next[31:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    always_comb
    begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        if (neg_reg)
            rsp.quot = big ? 32'sh80000000 : $signed(~quo_reg[31:0] + 32'd1);
        else
            rsp.quot = big ? 32'sh7fffffff : $signed(quo_reg[31:0]);
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import jls_pkg::*;

    localparam int N_MAX = 16;
    localparam int QUIET_LIMIT = 4000000;

    typedef struct {
        logic [3:0]         idx;
        logic signed [31:0] val;
        logic [1:0]         outcome;
        logic               last;
    } solution_word_t;

    typedef struct {
        logic [3:0]         row;
        logic [4:0]         col;
        logic signed [31:0] val;
        logic               last;
        logic               typed;
    } element_word_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    jacobi_linear_system_solver i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // solver state mirror
    logic signed [31:0] coef [N_MAX][N_MAX+1];
    logic               written [N_MAX][N_MAX+1];
    logic signed [31:0] x_prev [N_MAX];
    logic signed [31:0] x_cur [N_MAX];
    logic [4:0]  size_reg;
    logic [16:0] tol_reg;
    logic [15:0] cap_reg;

    solution_word_t pending_solutions [$];
    int idle_mode;
    int errors;
    int words_sent;
    int words_checked;
    int solves;
    int quiet_cycles;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int active_n();
        if (size_reg == 5'd0)
            return 1;
        if (size_reg > N_MAX)
            return N_MAX;
        return int'(size_reg);
    endfunction

    task automatic solve_system(input logic typed);
        int n;
        int i;
        int j;
        int cap;
        int sweeps;
        logic dom;
        longint diag;
        longint total;
        longint d;
        longint acc;
        longint p;
        longint diff;
        longint worst;
        logic [1:0] outcome;
        solution_word_t w;
        n = active_n();
        solves++;
        dom = 1'b1;
        for (i = 0; i < n; i++)
        begin
            diag = mag(longint'(coef[i][i]));
            total = 0;
            for (j = 0; j < n; j++)
                if (j != i)
                    total += mag(longint'(coef[i][j]));
            if (diag <= total)
                dom = 1'b0;
        end
        if (!dom)
        begin
            w.idx = 4'd0;
            w.val = 32'sd0;
            w.outcome = OUT_NOT_DOMINANT;
            w.last = 1'b1;
            pending_solutions.push_back(w);
            return;
        end
        if (typed)
        begin
            $error("typed row expects no dominance but system is dominant");
            errors++;
        end
        for (i = 0; i < n; i++)
        begin
            d = coef[i][i];
            for (j = 0; j < n; j++)
                if (j == i)
                    coef[i][j] = 32'sd0;
                else
                    coef[i][j] = clamp32((-longint'(coef[i][j]) * 65536) / d);
            coef[i][n] = clamp32((longint'(coef[i][n]) * 65536) / d);
        end
        cap = (cap_reg == 16'd0) ? 1 : int'(cap_reg);
        for (i = 0; i < N_MAX; i++)
            x_prev[i] = 32'sd0;
        sweeps = 0;
        forever
        begin
            worst = 0;
            for (i = 0; i < n; i++)
            begin
                acc = coef[i][n];
                for (j = 0; j < n; j++)
                begin
                    p = longint'(coef[i][j]) * longint'(x_prev[j]);
                    acc += clamp32(p >>> 16);
                end
                x_cur[i] = clamp32(acc);
                diff = mag(longint'(x_cur[i]) - longint'(x_prev[i]));
                if (diff > worst)
                    worst = diff;
            end
            for (i = 0; i < n; i++)
                x_prev[i] = x_cur[i];
            sweeps++;
            if (worst <= tol_reg)
            begin
                outcome = OUT_CONVERGED;
                break;
            end
            if (sweeps >= cap)
            begin
                outcome = OUT_CAP_REACHED;
                break;
            end
        end
        for (i = 0; i < n; i++)
        begin
            w.idx = 4'(i);
            w.val = x_cur[i];
            w.outcome = outcome;
            w.last = (i == n - 1);
            pending_solutions.push_back(w);
        end
    endtask

    task automatic send_element(input element_word_t e);
        while ($urandom_range(99) < ((idle_mode == 1) ? 63 : (idle_mode == 3) ? 9 : 0))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, e.val, e.col, e.row};
        s_axis_tlast <= e.last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
        if (e.row < N_MAX && e.col <= N_MAX)
        begin
            coef[e.row][e.col] = e.val;
            written[e.row][e.col] = 1'b1;
        end
        if (e.last)
            solve_system(e.typed);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SIZE)
            size_reg = v[4:0];
        else if (idx == REG_TOL)
            tol_reg = v;
        else if (idx == REG_CAP)
            cap_reg = v[15:0];
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_solutions.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_sign(input logic [31:0] m);
        return $urandom_range(1) ? -$signed(m) : $signed(m);
    endfunction

    // kind: 0 dominant, 1 arbitrary, 2 rerun on stored form
    task automatic load_system(input int kind);
        element_word_t list [$];
        element_word_t e;
        element_word_t t;
        int n;
        int r;
        int c;
        int k;
        int sh;
        logic [31:0] dm;
        logic [31:0] lim;
        n = active_n();
        e.typed = 1'b0;
        e.last = 1'b0;
        repeat ($urandom_range(2))
        begin
            e.row = 4'($urandom);
            e.col = 5'($urandom_range(31, 17));
            e.val = $urandom;
            send_element(e);
        end
        if (kind == 2)
        begin
            e.row = 4'($urandom);
            e.col = 5'($urandom_range(31, 17));
            e.val = $urandom;
            e.last = 1'b1;
            send_element(e);
            return;
        end
        for (r = 0; r < n; r++)
        begin
            sh = $urandom_range(16);
            dm = ($urandom >> (sh + 1)) | 32'h100;
            lim = dm / (2 * n);
            for (c = 0; c <= n; c++)
            begin
                e.row = 4'(r);
                e.col = 5'(c);
                if (kind == 1)
                    e.val = $urandom >> $urandom_range(20);
                else if (c == r)
                    e.val = rand_sign(dm);
                else if (c == n)
                    e.val = $signed($urandom) >>> $urandom_range(12);
                else
                    e.val = rand_sign($urandom_range(lim, 0));
                if (kind == 1 && $urandom_range(1))
                    e.val = -e.val;
                list.push_back(e);
            end
        end
        for (k = list.size() - 1; k > 0; k--)
        begin
            r = $urandom_range(k);
            t = list[k];
            list[k] = list[r];
            list[r] = t;
        end
        list[list.size() - 1].last = 1'b1;
        foreach (list[k])
            send_element(list[k]);
    endtask

    function automatic logic loaded();
        int n;
        n = active_n();
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= n; c++)
                if (!written[r][c])
                    return 1'b0;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        solution_word_t w;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_solutions.size() == 0)
                begin
                    $error("unexpected result word %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    w = pending_solutions.pop_front();
                    words_checked++;
                    if (m_axis_tdata[3:0] !== w.idx)
                    begin
                        $error("unknown_index exp %0d got %0d", w.idx, m_axis_tdata[3:0]);
                        errors++;
                    end
                    if ($signed(m_axis_tdata[35:4]) !== w.val)
                    begin
                        $error("solution_value exp %0d got %0d", w.val,
                            $signed(m_axis_tdata[35:4]));
                        errors++;
                    end
                    if (m_axis_tdata[37:36] !== w.outcome)
                    begin
                        $error("outcome exp %0d got %0d", w.outcome, m_axis_tdata[37:36]);
                        errors++;
                    end
                    if (m_axis_tlast !== w.last)
                    begin
                        $error("final_result exp %0d got %0d", w.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            m_axis_tready <= !($urandom_range(99) <
                ((idle_mode == 2) ? 63 : (idle_mode == 3) ? 9 : 0));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    element_word_t directed [] = '{
        '{4'd0, 5'd0, 32'sd0, 1'b0, 1'b0},
        '{4'd0, 5'd1, 32'sd0, 1'b0, 1'b0},
        '{4'd0, 5'd2, 32'sd0, 1'b0, 1'b0},
        '{4'd1, 5'd0, 32'sd0, 1'b0, 1'b0},
        '{4'd1, 5'd1, 32'sd0, 1'b0, 1'b0},
        '{4'd1, 5'd2, 32'sd0, 1'b1, 1'b1},
        '{4'd0, 5'd0, 32'sh80000000, 1'b0, 1'b0},
        '{4'd0, 5'd1, 32'sh00000001, 1'b0, 1'b0},
        '{4'd0, 5'd2, 32'sh7fffffff, 1'b0, 1'b0},
        '{4'd1, 5'd0, -32'sh00010000, 1'b0, 1'b0},
        '{4'd1, 5'd1, 32'sh00040000, 1'b0, 1'b0},
        '{4'd1, 5'd2, -32'sh7fffffff, 1'b1, 1'b0},
        '{4'd15, 5'd16, 32'shffffffff, 1'b0, 1'b0},
        '{4'd15, 5'd31, 32'sh5a5a5a5a, 1'b1, 1'b1},
        '{4'd0, 5'd0, 32'sh7fffffff, 1'b0, 1'b0},
        '{4'd0, 5'd1, 32'sh7ffffffe, 1'b0, 1'b0},
        '{4'd0, 5'd2, 32'sh7fffffff, 1'b0, 1'b0},
        '{4'd1, 5'd0, 32'sh00000001, 1'b0, 1'b0},
        '{4'd1, 5'd1, 32'sh00000002, 1'b0, 1'b0},
        '{4'd1, 5'd2, 32'sh80000000, 1'b1, 1'b0},
        '{4'd1, 5'd1, 32'sh00000001, 1'b1, 1'b1}
    };

    int phase_size [8] = '{1, 3, 0, 4, 31, 2, 6, 5};
    int phase_tol  [8] = '{65536, 66, 0, 1, 4096, 0, 66, 1000};
    int phase_cap  [8] = '{1, 65535, 0, 50, 8, 30, 3, 1000};

    initial
    begin
        int ph;
        int cnt;
        int sel;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SIZE;
        cfg_data = '0;
        size_reg = SIZE_RST;
        tol_reg = TOL_RST;
        cap_reg = CAP_RST;
        idle_mode = 0;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        solves = 0;
        foreach (written[r, c])
            written[r][c] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_SIZE, 17'd2);
        foreach (directed[k])
            send_element(directed[k]);
        drain();

        for (ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_SIZE, CFG_DATA_W'(phase_size[ph]));
            write_reg(REG_TOL, CFG_DATA_W'(phase_tol[ph]));
            write_reg(REG_CAP, CFG_DATA_W'(phase_cap[ph]));
            idle_mode = ph % 4;
            cnt = words_sent;
            load_system(0);
            while (words_sent - cnt < 20 && active_n() < N_MAX)
            begin
                sel = $urandom_range(9);
                if (sel == 0)
                    load_system(1);
                else if (sel == 1 && loaded())
                    load_system(2);
                else
                    load_system(0);
            end
            drain();
        end

        idle_mode = 0;
        repeat (100) @(posedge clk);
        $display("covered %0d element words, %0d solves, %0d result words checked",
            words_sent, solves, words_checked);
        $display("sizes 1 to 16 incl. out-of-range, tolerance and cap extremes, four idle mixes");
        if (errors == 0 && pending_solutions.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/jls_pkg.sv
sv/jls_ram.sv
sv/jls_div.sv
sv/jacobi_linear_system_solver.sv
bench/tb.sv
